// File: sv/rqpx_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rqpx_pkg
// Shared sizes, codes and types for the ring queue with priority extract.
// -----------------------------------------------------------------------------
package rqpx_pkg;

   // Queue depth; index arithmetic wraps by natural overflow, so keep it a power of two
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 4;
   localparam int PRIO_W  = 3;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Item kinds
   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // Dequeue policy
   localparam logic POLICY_PRIO = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // One candidate handed from the sequencer to the compare unit
   typedef struct packed {
      logic             valid;
      logic             first;
      logic [CNT_W-1:0] off;
   } cand_type;

endpackage

// File: sv/rqpx_store.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rqpx_store
// Entry memory: one write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module rqpx_store
   import rqpx_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rqpx_min_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rqpx_min_unit
// Compare unit: tracks the oldest entry with the lowest priority value.
// -----------------------------------------------------------------------------
module rqpx_min_unit
   import rqpx_pkg::*;
(
   input  logic             clock,
   input  cand_type         cand,
   input  entry_type        cand_entry,
   output logic [ID_W-1:0]  best_id,
   output logic [CNT_W-1:0] best_off
);

   logic [PRIO_W-1:0] best_prio_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic [CNT_W-1:0]  best_off_ff;
   logic              take;

   // Strict less-than keeps the older entry on a tie
   assign take = cand.valid && (cand.first || (cand_entry.prio < best_prio_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_prio_ff <= cand_entry.prio;
         best_id_ff   <= cand_entry.id;
         best_off_ff  <= cand.off;
      end
   end

   assign best_id  = best_id_ff;
   assign best_off = best_off_ff;

endmodule

// File: sv/ring_queue_with_priority_extract.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ring_queue_with_priority_extract
// Circular queue of client ids with per-entry priority; FIFO or priority dequeue.
// -----------------------------------------------------------------------------
// Sequence: enqueue and refused items pass through FINISH to the output register,
//   FIFO dequeue through HEAD and FINISH, priority dequeue through a scan of count
//   entries, then a shift of the later entries (one memory read per cycle), then FINISH.
// Throughput: one item at a time; the next item is taken once the result is
//   loaded into the output register.
// Reset: queue pointers, count, policy and handshakes clear; store contents
//   stay undefined and are never read before written.
// -----------------------------------------------------------------------------
module ring_queue_with_priority_extract
   import rqpx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] entry_id, [6:4] entry_priority
   input  logic                  req_tuser,  // [0] kind
   // Result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] out_id, [5:4] status, [10:6] occupancy
   // Policy register
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HEAD   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      off_ff, off_in;
   logic                  pend_ff, pend_in;
   logic [CNT_W-1:0]      pend_off_ff, pend_off_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic [STAT_W-1:0]     res_status_ff, res_status_in;
   logic                  policy_ff, policy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  in_kind;
   entry_type             in_entry;
   logic                  issue;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;
   logic [IDX_W-1:0]      rd_addr;
   entry_type             rd_data;
   cand_type              cand;
   logic [ID_W-1:0]       best_id;
   logic [CNT_W-1:0]      best_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_kind    = req_tuser;
   assign in_entry.id   = req_tdata[ID_W-1:0];
   assign in_entry.prio = req_tdata[ID_W+PRIO_W-1:ID_W];

   assign issue = ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT)) && (off_ff < count_ff);
   assign rd_addr = ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT)) ?
                    IDX_W'(head_ff + off_ff[IDX_W-1:0]) : head_ff;

   assign cand.valid = (state_ff == ST_SCAN) && pend_ff;
   assign cand.first = (pend_off_ff == '0);
   assign cand.off   = pend_off_ff;

   rqpx_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rqpx_min_unit u_min (
      .clock      (clock),
      .cand       (cand),
      .cand_entry (rd_data),
      .best_id    (best_id),
      .best_off   (best_off)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      pend_in       = 1'b0;
      pend_off_in   = pend_off_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      policy_in     = csr_wr_en ? csr_wr_data : policy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = in_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_id_in     = '0;
               res_status_in = STAT_DONE;
               state_in      = ST_FINISH;
               if (in_kind == KIND_ENQ) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = IDX_W'(tail_ff + IDX_W'(1));
                     count_in = CNT_W'(count_ff + CNT_W'(1));
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STAT_EMPTY;
               end else if (policy_ff == POLICY_FIFO) begin
                  // head entry is already being read
                  state_in = ST_HEAD;
               end else begin
                  off_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_HEAD: begin
            res_id_in = rd_data.id;
            head_in   = IDX_W'(head_ff + IDX_W'(1));
            count_in  = CNT_W'(count_ff - CNT_W'(1));
            state_in  = ST_FINISH;
         end
         ST_SCAN: begin
            if (issue) begin
               off_in      = CNT_W'(off_ff + CNT_W'(1));
               pend_in     = 1'b1;
               pend_off_in = off_ff;
            end else if (!pend_ff) begin
               // start moving entries after the selected one
               off_in   = CNT_W'(best_off + CNT_W'(1));
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (issue) begin
               off_in      = CNT_W'(off_ff + CNT_W'(1));
               pend_in     = 1'b1;
               pend_off_in = off_ff;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(head_ff + pend_off_ff[IDX_W-1:0] - IDX_W'(1));
               wr_data = rd_data;
            end
            if (!issue && !pend_ff) begin
               res_id_in = best_id;
               tail_in   = IDX_W'(tail_ff - IDX_W'(1));
               count_in  = CNT_W'(count_ff - CNT_W'(1));
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({OCC_W'(count_ff), res_status_ff, res_id_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         policy_ff    <= POLICY_PRIO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      pend_off_ff   <= pend_off_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Pointers and count stay consistent around the ring
   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == IDX_W'(head_ff + count_ff[IDX_W-1:0]))
      else $error("tail pointer out of step with head and count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // An accepted item leaves the block not ready in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("ready right after accept");

   a_empty_result_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[ID_W+STAT_W-1:ID_W] != STAT_DONE)) |->
         (rsp_tdata[ID_W-1:0] == '0))
      else $error("refused item carries an id");

endmodule
